>>> sv/itp_pkg.sv
// ----------------------------------------------------------------------------
// itp_pkg
// Shared constants, character codes, state encoding and decode struct for
// the infix to prefix converter.
// ----------------------------------------------------------------------------
package itp_pkg;

    localparam int MAX_LEN = 64;
    localparam int ADDR_W  = $clog2(MAX_LEN);
    localparam int CNT_W   = $clog2(MAX_LEN + 1);
    localparam int CHAR_W  = 8;

    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_STAR  = 8'h2A;
    localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;
    localparam logic [CHAR_W-1:0] CH_CARET = 8'h5E;
    localparam logic [CHAR_W-1:0] CH_OPEN  = 8'h28;
    localparam logic [CHAR_W-1:0] CH_CLOSE = 8'h29;
    localparam logic [CHAR_W-1:0] CH_LO_A  = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LO_Z  = 8'h7A;
    localparam logic [CHAR_W-1:0] CH_UP_A  = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UP_Z  = 8'h5A;
    localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;

    typedef enum logic [4:0] {
        S_LOAD  = 5'b00001,
        S_FETCH = 5'b00010,
        S_EXEC  = 5'b00100,
        S_DRAIN = 5'b01000,
        S_EMIT  = 5'b10000
    } t_state;

    typedef struct packed {
        logic is_letter;
        logic is_open;
        logic is_close;
        logic is_oper;
        logic top_higher;
        logic top_is_close;
    } t_op_info;

endpackage

>>> sv/itp_ram.sv
// ----------------------------------------------------------------------------
// itp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module itp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> sv/itp_op_unit.sv
// ----------------------------------------------------------------------------
// itp_op_unit
// Character classifier and priority comparator shared by every scan step.
// ----------------------------------------------------------------------------
module itp_op_unit
    import itp_pkg::*;
(
    input  logic [CHAR_W-1:0] i_char,
    input  logic [CHAR_W-1:0] i_top,
    output t_op_info          o_info
);

    function automatic logic [1:0] prio_code(input logic [CHAR_W-1:0] c);
        logic [1:0] p;
        p = 2'd0;
        if (c == CH_PLUS || c == CH_MINUS) begin
            p = 2'd1;
        end else if (c == CH_STAR || c == CH_SLASH) begin
            p = 2'd2;
        end else if (c == CH_CARET) begin
            p = 2'd3;
        end
        return p;
    endfunction

    always_comb begin
        o_info.is_letter    = ((i_char >= CH_LO_A) && (i_char <= CH_LO_Z)) ||
                              ((i_char >= CH_UP_A) && (i_char <= CH_UP_Z));
        o_info.is_open      = (i_char == CH_OPEN);
        o_info.is_close     = (i_char == CH_CLOSE);
        o_info.is_oper      = (i_char == CH_PLUS) || (i_char == CH_MINUS) ||
                              (i_char == CH_STAR) || (i_char == CH_SLASH) ||
                              (i_char == CH_CARET);
        o_info.top_higher   = (prio_code(i_top) > prio_code(i_char));
        o_info.top_is_close = (i_top == CH_CLOSE);
    end

endmodule

>>> sv/infix_to_prefix_converter.sv
// ----------------------------------------------------------------------------
// infix_to_prefix_converter
// Infix to prefix conversion with an operator stack, right-to-left scan.
//
// Usage:
//   Requests: drive i_in_char / i_in_last with start; a request is taken at
//   a rising edge where start is high and busy is low. Characters load at
//   one per cycle; up to MAX_LEN are stored, later ones are dropped and
//   flagged on o_overflow.
//   The request carrying i_in_last starts the conversion and raises busy.
//   Conversion reads each stored character from the store, then executes
//   it, with one more execute step per stack entry moved to the buffer,
//   and a final fetch step closes the scan; the drain moves each remaining
//   stack entry to the buffer, then issues the first buffer read. Emission
//   then gives one result per cycle from the buffer's single read port.
//   Each result appears for one cycle with o_out_valid; o_out_last marks the
//   final one. An empty prefix string gives a single result with o_out_empty.
//   The receiver cannot stall; busy drops in the cycle that carries the last
//   result, so the next request can be taken at the edge that ends it.
//   Reset returns the block to loading with all counts cleared.
// ----------------------------------------------------------------------------
module infix_to_prefix_converter
    import itp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [CHAR_W-1:0] i_in_char,
    input  logic              i_in_last,
    output logic              o_out_valid,
    output logic [CHAR_W-1:0] o_out_char,
    output logic              o_out_last,
    output logic              o_out_empty,
    output logic              o_overflow
);

    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_LEN);
    localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);
    localparam logic [CNT_W-1:0] CNT_TWO = CNT_W'(2);

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [CNT_W-1:0]  r_k, n_k;
    logic [CNT_W-1:0]  r_sp, n_sp;
    logic [CNT_W-1:0]  r_bc, n_bc;
    logic [ADDR_W-1:0] r_idx, n_idx;
    logic              r_ovf, n_ovf;
    logic              r_top_ram, n_top_ram;
    logic [CHAR_W-1:0] r_top, n_top;
    logic              r_out_valid, n_out_valid;
    logic [CHAR_W-1:0] r_out_char, n_out_char;
    logic              r_out_last, n_out_last;
    logic              r_out_empty, n_out_empty;
    logic              r_out_ovf, n_out_ovf;

    logic              st_we, st_re;
    logic [ADDR_W-1:0] st_waddr, st_raddr;
    logic [CHAR_W-1:0] st_rdata;
    logic              sk_we, sk_re;
    logic [ADDR_W-1:0] sk_waddr, sk_raddr;
    logic [CHAR_W-1:0] sk_wdata, sk_rdata;
    logic              bf_we, bf_re;
    logic [ADDR_W-1:0] bf_waddr, bf_raddr;
    logic [CHAR_W-1:0] bf_wdata, bf_rdata;

    logic [CHAR_W-1:0] w_top;
    t_op_info          w_info;
    logic              do_put, do_pop, do_push;
    logic [CHAR_W-1:0] put_char, push_char;
    logic [CNT_W-1:0]  w_k_m1, w_sp_m2, w_bc_m1;

    itp_ram #(.WIDTH(CHAR_W), .DEPTH(MAX_LEN)) u_store (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (st_waddr),
        .i_wdata (i_in_char),
        .i_re    (st_re),
        .i_raddr (st_raddr),
        .o_rdata (st_rdata)
    );

    itp_ram #(.WIDTH(CHAR_W), .DEPTH(MAX_LEN)) u_stack (
        .i_clk   (i_clk),
        .i_we    (sk_we),
        .i_waddr (sk_waddr),
        .i_wdata (sk_wdata),
        .i_re    (sk_re),
        .i_raddr (sk_raddr),
        .o_rdata (sk_rdata)
    );

    itp_ram #(.WIDTH(CHAR_W), .DEPTH(MAX_LEN)) u_buffer (
        .i_clk   (i_clk),
        .i_we    (bf_we),
        .i_waddr (bf_waddr),
        .i_wdata (bf_wdata),
        .i_re    (bf_re),
        .i_raddr (bf_raddr),
        .o_rdata (bf_rdata)
    );

    assign w_top = r_top_ram ? sk_rdata : r_top;

    itp_op_unit u_op (
        .i_char (st_rdata),
        .i_top  (w_top),
        .o_info (w_info)
    );

    assign w_k_m1  = r_k - CNT_ONE;
    assign w_sp_m2 = r_sp - CNT_TWO;
    assign w_bc_m1 = r_bc - CNT_ONE;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_k         = r_k;
        n_sp        = r_sp;
        n_bc        = r_bc;
        n_idx       = r_idx;
        n_ovf       = r_ovf;
        n_top_ram   = r_top_ram;
        n_top       = r_top;
        n_out_valid = 1'b0;
        n_out_char  = r_out_char;
        n_out_last  = r_out_last;
        n_out_empty = r_out_empty;
        n_out_ovf   = r_out_ovf;
        st_we       = 1'b0;
        st_re       = 1'b0;
        st_waddr    = r_cnt[ADDR_W-1:0];
        st_raddr    = w_k_m1[ADDR_W-1:0];
        sk_we       = 1'b0;
        sk_re       = 1'b0;
        sk_waddr    = r_sp[ADDR_W-1:0];
        sk_raddr    = w_sp_m2[ADDR_W-1:0];
        sk_wdata    = CH_NUL;
        bf_we       = 1'b0;
        bf_re       = 1'b0;
        bf_waddr    = r_bc[ADDR_W-1:0];
        bf_raddr    = w_bc_m1[ADDR_W-1:0];
        bf_wdata    = CH_NUL;
        do_put      = 1'b0;
        do_pop      = 1'b0;
        do_push     = 1'b0;
        put_char    = w_top;
        push_char   = st_rdata;

        unique case (r_state)
            S_LOAD: begin
                if (start) begin
                    if (r_cnt < CNT_MAX) begin
                        st_we = 1'b1;
                        n_cnt = r_cnt + CNT_ONE;
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_in_last) begin
                        n_k     = (r_cnt < CNT_MAX) ? (r_cnt + CNT_ONE) : r_cnt;
                        n_sp    = '0;
                        n_bc    = '0;
                        n_state = S_FETCH;
                    end
                end
            end
            S_FETCH: begin
                if (r_k == '0) begin
                    n_state = S_DRAIN;
                end else begin
                    st_re   = 1'b1;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_k     = w_k_m1;
                n_state = S_FETCH;
                if (w_info.is_letter) begin
                    do_put   = 1'b1;
                    put_char = st_rdata;
                end else if (w_info.is_close) begin
                    do_push = 1'b1;
                end else if (w_info.is_oper) begin
                    if (r_sp != '0 && w_info.top_higher) begin
                        do_put  = 1'b1;
                        do_pop  = 1'b1;
                        n_k     = r_k;
                        n_state = S_EXEC;
                    end else begin
                        do_push = 1'b1;
                    end
                end else if (w_info.is_open) begin
                    do_pop = 1'b1;
                    if (r_sp != '0 && !w_info.top_is_close) begin
                        do_put  = 1'b1;
                        n_k     = r_k;
                        n_state = S_EXEC;
                    end
                end
            end
            S_DRAIN: begin
                if (r_sp != '0) begin
                    do_put = 1'b1;
                    do_pop = 1'b1;
                end else if (r_bc == '0) begin
                    n_out_valid = 1'b1;
                    n_out_char  = CH_NUL;
                    n_out_last  = 1'b1;
                    n_out_empty = 1'b1;
                    n_out_ovf   = r_ovf;
                    n_cnt       = '0;
                    n_ovf       = 1'b0;
                    n_state     = S_LOAD;
                end else begin
                    bf_re   = 1'b1;
                    n_idx   = w_bc_m1[ADDR_W-1:0];
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                n_out_valid = 1'b1;
                n_out_char  = bf_rdata;
                n_out_last  = (r_idx == '0);
                n_out_empty = 1'b0;
                n_out_ovf   = r_ovf;
                if (r_idx != '0) begin
                    bf_re    = 1'b1;
                    bf_raddr = r_idx - ADDR_W'(1);
                    n_idx    = r_idx - ADDR_W'(1);
                end else begin
                    n_cnt   = '0;
                    n_ovf   = 1'b0;
                    n_sp    = '0;
                    n_bc    = '0;
                    n_state = S_LOAD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase

        if (do_put && r_bc < CNT_MAX) begin
            bf_we    = 1'b1;
            bf_wdata = put_char;
            n_bc     = r_bc + CNT_ONE;
        end
        if (do_pop && r_sp != '0) begin
            n_sp = r_sp - CNT_ONE;
            if (r_sp >= CNT_TWO) begin
                sk_re     = 1'b1;
                n_top_ram = 1'b1;
            end
        end
        if (do_push && r_sp < CNT_MAX) begin
            sk_we     = 1'b1;
            sk_wdata  = push_char;
            n_sp      = r_sp + CNT_ONE;
            n_top     = push_char;
            n_top_ram = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_cnt       <= '0;
            r_k         <= '0;
            r_sp        <= '0;
            r_bc        <= '0;
            r_idx       <= '0;
            r_ovf       <= 1'b0;
            r_top_ram   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_k         <= n_k;
            r_sp        <= n_sp;
            r_bc        <= n_bc;
            r_idx       <= n_idx;
            r_ovf       <= n_ovf;
            r_top_ram   <= n_top_ram;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_top       <= n_top;
        r_out_char  <= n_out_char;
        r_out_last  <= n_out_last;
        r_out_empty <= n_out_empty;
        r_out_ovf   <= n_out_ovf;
    end

    assign busy        = (r_state != S_LOAD);
    assign o_out_valid = r_out_valid;
    assign o_out_char  = r_out_char;
    assign o_out_last  = r_out_last;
    assign o_out_empty = r_out_empty;
    assign o_overflow  = r_out_ovf;

endmodule

>>> tb/tb_infix_to_prefix_converter.sv
// ----------------------------------------------------------------------------
// tb_infix_to_prefix_converter
// Self-checking bench for the infix to prefix converter. Expressions are sent
// one character per request with random gaps, and a bench-side operator-stack
// converter works out the prefix string for each one. Every result strobe is
// compared field by field against the oldest prefix character still due. A
// short directed table covers the corner cases, followed by random
// expressions: mostly well formed, some broken or pure noise, and a few that
// fill or overrun the character store.
// ----------------------------------------------------------------------------
module tb_infix_to_prefix_converter
    import itp_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_REQUESTS = 250;
    localparam int DRAIN_CYCLES    = 5 * MAX_LEN + 64;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_ONES  = 8'hFF;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
        logic              empty;
        logic              ovf;
    } t_prefix_char;

    logic              i_clk     = 1'b0;
    logic              i_rst_n   = 1'b0;
    logic              start     = 1'b0;
    logic [CHAR_W-1:0] i_in_char = '0;
    logic              i_in_last = 1'b0;
    logic              busy;
    logic              o_out_valid;
    logic [CHAR_W-1:0] o_out_char;
    logic              o_out_last;
    logic              o_out_empty;
    logic              o_overflow;

    logic [CHAR_W-1:0] expr_chars[$];
    logic [CHAR_W-1:0] infix_held[$];
    logic [CHAR_W-1:0] prefix_chars[$];
    logic              infix_dropped = 1'b0;
    t_prefix_char      prefix_due[$];
    int                requests_sent = 0;
    int                mismatch_count = 0;

    // '#' stands for the zero code and '~' for all ones
    string dir_text   [8] = '{"1", "a", "a+b", ")", "(", "#Z~", "A^B^C", "(a-b)*c/d"};
    bit    dir_known  [8] = '{1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0};
    string dir_prefix [8] = '{"", "a", "+ab", ")", "", "Z", "", ""};

    infix_to_prefix_converter uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_in_char   (i_in_char),
        .i_in_last   (i_in_last),
        .o_out_valid (o_out_valid),
        .o_out_char  (o_out_char),
        .o_out_last  (o_out_last),
        .o_out_empty (o_out_empty),
        .o_overflow  (o_overflow)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic int op_rank(logic [CHAR_W-1:0] c);
        case (c)
            CH_PLUS, CH_MINUS: return 0;
            CH_STAR, CH_SLASH: return 1;
            CH_CARET:          return 2;
            default:           return -1;
        endcase
    endfunction

    function automatic bit is_letter(logic [CHAR_W-1:0] c);
        return (c >= CH_LO_A && c <= CH_LO_Z) || (c >= CH_UP_A && c <= CH_UP_Z);
    endfunction

    function automatic void build_prefix();
        logic [CHAR_W-1:0] opstack[$];
        logic [CHAR_W-1:0] rev[$];
        logic [CHAR_W-1:0] c;
        prefix_chars.delete();
        for (int k = infix_held.size() - 1; k >= 0; k--) begin
            c = infix_held[k];
            if (is_letter(c)) begin
                rev.push_back(c);
            end else if (c == CH_CLOSE) begin
                opstack.push_back(c);
            end else if (op_rank(c) >= 0) begin
                while (opstack.size() > 0 && op_rank(opstack[$]) > op_rank(c))
                    rev.push_back(opstack.pop_back());
                opstack.push_back(c);
            end else if (c == CH_OPEN) begin
                while (opstack.size() > 0 && opstack[$] != CH_CLOSE)
                    rev.push_back(opstack.pop_back());
                if (opstack.size() > 0) void'(opstack.pop_back());
            end
        end
        while (opstack.size() > 0)
            rev.push_back(opstack.pop_back());
        for (int k = rev.size() - 1; k >= 0; k--)
            prefix_chars.push_back(rev[k]);
    endfunction

    function automatic logic [CHAR_W-1:0] pick_letter();
        if ($urandom_range(0, 1) == 1) return CH_LO_A + CHAR_W'($urandom_range(0, 25));
        return CH_UP_A + CHAR_W'($urandom_range(0, 25));
    endfunction

    function automatic logic [CHAR_W-1:0] pick_oper();
        case ($urandom_range(0, 4))
            0:       return CH_PLUS;
            1:       return CH_MINUS;
            2:       return CH_STAR;
            3:       return CH_SLASH;
            default: return CH_CARET;
        endcase
    endfunction

    function automatic logic [CHAR_W-1:0] dir_code(byte b);
        case (b)
            "#":     return CH_NUL;
            "~":     return CH_ONES;
            default: return b;
        endcase
    endfunction

    task automatic add_term(int depth);
        if (depth < 2 && $urandom_range(0, 3) == 0) begin
            expr_chars.push_back(CH_OPEN);
            add_expr(depth + 1);
            expr_chars.push_back(CH_CLOSE);
        end else begin
            expr_chars.push_back(pick_letter());
        end
        if ($urandom_range(0, 7) == 0)
            expr_chars.push_back($urandom_range(0, 1) == 1 ? CH_SPACE
                                 : CH_ZERO + CHAR_W'($urandom_range(0, 9)));
    endtask

    task automatic add_expr(int depth);
        int n;
        n = $urandom_range(0, 3);
        add_term(depth);
        repeat (n) begin
            expr_chars.push_back(pick_oper());
            add_term(depth);
        end
    endtask

    task automatic send_char(input logic [CHAR_W-1:0] c, input logic last, input int gap);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start     <= 1'b1;
        i_in_char <= c;
        i_in_last <= last;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        requests_sent++;
        if (infix_held.size() < MAX_LEN) infix_held.push_back(c);
        else infix_dropped = 1'b1;
    endtask

    task automatic send_expr(input bit known, input string typed);
        bit burst;
        int gap;
        burst = ($urandom_range(0, 3) == 0);
        foreach (expr_chars[i]) begin
            gap = burst ? 0 : $urandom_range(0, 14);
            send_char(expr_chars[i], i == expr_chars.size() - 1, gap);
        end
        build_prefix();
        if (known) begin
            prefix_chars.delete();
            for (int i = 0; i < typed.len(); i++) prefix_chars.push_back(typed[i]);
        end
        if (prefix_chars.size() == 0) begin
            prefix_due.push_back('{ch: CH_NUL, last: 1'b1, empty: 1'b1, ovf: infix_dropped});
        end else begin
            foreach (prefix_chars[k])
                prefix_due.push_back('{ch: prefix_chars[k], last: k == prefix_chars.size() - 1,
                                       empty: 1'b0, ovf: infix_dropped});
        end
        infix_held.delete();
        infix_dropped = 1'b0;
    endtask

    task automatic check_field(string name, logic [CHAR_W-1:0] want, logic [CHAR_W-1:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %h got %h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_prefix_char want;
        if (i_rst_n && o_out_valid) begin
            if (prefix_due.size() == 0) begin
                $display("%0t: result expected none got char %h last %b empty %b overflow %b",
                         $time, o_out_char, o_out_last, o_out_empty, o_overflow);
                mismatch_count++;
            end else begin
                want = prefix_due.pop_front();
                check_field("out_char", want.ch, o_out_char);
                check_field("out_last", CHAR_W'(want.last), CHAR_W'(o_out_last));
                check_field("out_empty", CHAR_W'(want.empty), CHAR_W'(o_out_empty));
                check_field("overflow", CHAR_W'(want.ovf), CHAR_W'(o_overflow));
            end
        end
    end

    initial begin
        int base;
        int expr_idx;
        int target;
        int sel;
        int pos;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < 8; r++) begin
            expr_chars.delete();
            for (int i = 0; i < dir_text[r].len(); i++)
                expr_chars.push_back(dir_code(dir_text[r][i]));
            send_expr(dir_known[r], dir_prefix[r]);
        end

        base = requests_sent;
        expr_idx = 0;
        while (requests_sent - base < RANDOM_REQUESTS) begin
            expr_chars.delete();
            if (expr_idx == 2 || expr_idx == 5) begin
                target = (expr_idx == 2) ? $urandom_range(MAX_LEN + 1, MAX_LEN + 6) : MAX_LEN;
                while (expr_chars.size() < target) begin
                    if (expr_chars.size() > 0) expr_chars.push_back(pick_oper());
                    add_expr(0);
                end
                while (expr_chars.size() > target) void'(expr_chars.pop_back());
            end else begin
                sel = $urandom_range(0, 9);
                if (sel == 0) begin
                    repeat ($urandom_range(1, 10))
                        expr_chars.push_back(CHAR_W'($urandom_range(0, 255)));
                end else begin
                    add_expr(0);
                    if (sel == 1) begin
                        if ($urandom_range(0, 1) == 1 && expr_chars.size() > 1) begin
                            expr_chars.delete($urandom_range(0, expr_chars.size() - 1));
                        end else begin
                            pos = $urandom_range(0, expr_chars.size());
                            case ($urandom_range(0, 2))
                                0:       expr_chars.insert(pos, CH_OPEN);
                                1:       expr_chars.insert(pos, CH_CLOSE);
                                default: expr_chars.insert(pos, pick_oper());
                            endcase
                        end
                    end
                end
            end
            send_expr(1'b0, "");
            expr_idx++;
        end
        start <= 1'b0;

        while (prefix_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("infix_to_prefix_converter test passed");
        else
            $display("infix_to_prefix_converter test failed");
        $finish;
    end

    initial begin
        #10_000_000;
        $display("infix_to_prefix_converter test failed");
        $finish;
    end

endmodule
